// File: sv/double_ended_priority_table_macros.svh
// Assertion macros used by the RTL controller.
`ifndef DOUBLE_ENDED_PRIORITY_TABLE_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent holds -> consequent holds in the same cycle.
`define DEPT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dept assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define DEPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dept assertion failed");

`else

`define DEPT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define DEPT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: sv/dept_pkg.sv
package dept_pkg;

   localparam int NUM_IDS    = 1024;
   localparam int NUM_LEVELS = 101;
   localparam int ID_W       = $clog2(NUM_IDS);
   localparam int LVL_W      = $clog2(NUM_LEVELS);

   localparam logic [LVL_W-1:0] MAX_LEVEL = LVL_W'(NUM_LEVELS - 1);
   localparam logic [ID_W-1:0]  LAST_ID   = ID_W'(NUM_IDS - 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic             present;
      logic [LVL_W-1:0] level;
   } entry_type;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] addr;
      entry_type       data;
   } store_wr_type;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] addr;
   } store_rd_type;

   typedef struct packed {
      logic            valid;
      logic            found;
      logic [ID_W-1:0] found_id;
   } result_type;

endpackage

// File: sv/dept_store.sv
module dept_store
   import dept_pkg::*;
(
   input  logic         clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output entry_type    rd_data
);

   entry_type mem [NUM_IDS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dept_ctrl.sv
`include "double_ended_priority_table_macros.svh"

module dept_ctrl
   import dept_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cmd_type          req_cmd,
   input  logic [ID_W-1:0]  req_id,
   input  logic [LVL_W-1:0] req_level,
   input  logic             req_highest,
   output store_wr_type     wr,
   output store_rd_type     rd,
   input  entry_type        rd_data,
   output result_type       result,
   input  logic             result_ready
);

   state_type        state_ff, state_in;
   logic [ID_W-1:0]  cnt_ff, cnt_in;
   logic             hi_ff, hi_in;
   logic             any_ff, any_in;
   logic [ID_W-1:0]  best_id_ff, best_id_in;
   logic [LVL_W-1:0] best_lvl_ff, best_lvl_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [ID_W-1:0]  rd_idx_ff, rd_idx_in;
   logic             req_fire;
   logic             clear_best;
   logic             take;
   logic [LVL_W-1:0] sat_level;

   assign req_fire  = req_valid && req_ready;
   assign sat_level = (req_level > MAX_LEVEL) ? MAX_LEVEL : req_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         hi_ff       <= 1'b0;
         any_ff      <= 1'b0;
         best_id_ff  <= '0;
         best_lvl_ff <= '0;
         rd_valid_ff <= 1'b0;
         rd_idx_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         hi_ff       <= hi_in;
         any_ff      <= any_in;
         best_id_ff  <= best_id_in;
         best_lvl_ff <= best_lvl_in;
         rd_valid_ff <= rd_valid_in;
         rd_idx_ff   <= rd_idx_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      hi_in       = hi_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      clear_best  = 1'b0;
      req_ready   = 1'b0;
      wr          = '0;
      rd          = '0;
      result      = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = cnt_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ID) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_cmd)
                  CMD_ADD: begin
                     wr.en           = 1'b1;
                     wr.addr         = req_id;
                     wr.data.present = 1'b1;
                     wr.data.level   = sat_level;
                  end
                  CMD_REMOVE: begin
                     wr.en   = 1'b1;
                     wr.addr = req_id;
                  end
                  CMD_QUERY: begin
                     hi_in      = req_highest;
                     cnt_in     = '0;
                     clear_best = 1'b1;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd.en       = 1'b1;
            rd.addr     = cnt_ff;
            rd_valid_in = 1'b1;
            rd_idx_in   = cnt_ff;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ID) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            result.valid    = 1'b1;
            result.found    = any_ff;
            result.found_id = best_id_ff;
            if (result_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ties: highest keeps the later id, lowest keeps the earlier one
   assign take = rd_valid_ff && rd_data.present &&
                 (!any_ff || (hi_ff ? (rd_data.level >= best_lvl_ff)
                                    : (rd_data.level <  best_lvl_ff)));

   always_comb begin
      any_in      = any_ff;
      best_id_in  = best_id_ff;
      best_lvl_in = best_lvl_ff;
      if (clear_best) begin
         any_in      = 1'b0;
         best_id_in  = '0;
         best_lvl_in = '0;
      end else if (take) begin
         any_in      = 1'b1;
         best_id_in  = rd_idx_ff;
         best_lvl_in = rd_data.level;
      end
   end

   `DEPT_ASSERT_NEXT(a_query_starts_scan, clock, reset,
      req_fire && req_cmd == CMD_QUERY, state_ff == ST_SCAN && cnt_ff == '0)
   `DEPT_ASSERT_NOW(a_no_write_in_scan, clock, reset,
      state_ff == ST_SCAN || state_ff == ST_DRAIN || state_ff == ST_RESULT, !wr.en)
   `DEPT_ASSERT_NOW(a_empty_gives_zero, clock, reset,
      !any_ff, best_id_ff == '0)
   `DEPT_ASSERT_NEXT(a_drain_after_last_read, clock, reset,
      state_ff == ST_SCAN && cnt_ff == LAST_ID, rd_valid_ff && state_ff == ST_DRAIN)

endmodule

// File: sv/double_ended_priority_table.sv
// Channel   Dir  Ports             Fields (tdata/tuser, low bit first)
// req       in   req_t*            tuser: cmd; tdata: entry_id, entry_level, want_highest
// rsp       out  rsp_t*            tdata: found_id, found
//
// Add and remove each do a single store write.
// A query does one memory read per id slot, then drain and result.
// After reset a clearing sweep over every id slot runs before the first item is taken.
// req_tready is low during a query; a pending rsp item holds the query result stage.
module double_ended_priority_table
   import dept_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // entry_id[9:0], entry_level[16:10], want_highest[17]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // found_id[9:0], found[10]
);

   store_wr_type    wr;
   store_rd_type    rd;
   entry_type       rd_data;
   result_type      result;
   logic            result_ready;
   logic            rsp_valid_ff;
   logic            rsp_found_ff;
   logic [ID_W-1:0] rsp_id_ff;

   assign result_ready = !rsp_valid_ff || rsp_tready;

   dept_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_cmd      (cmd_type'(req_tuser)),
      .req_id       (req_tdata[ID_W-1:0]),
      .req_level    (req_tdata[ID_W +: LVL_W]),
      .req_highest  (req_tdata[ID_W+LVL_W]),
      .wr           (wr),
      .rd           (rd),
      .rd_data      (rd_data),
      .result       (result),
      .result_ready (result_ready)
   );

   dept_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_ready) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result_ready && result.valid) begin
         rsp_found_ff <= result.found;
         rsp_id_ff    <= result.found_id;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_found_ff, rsp_id_ff};

endmodule

// File: tb/double_ended_priority_table_test.sv
module double_ended_priority_table_test;
   import dept_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int PACE_STEADY     = 0;
   localparam int PACE_SEND_IDLE  = 1;
   localparam int PACE_RECV_STALL = 2;
   localparam int PACE_BOTH       = 3;
   localparam int PACE_SPAN       = 70;

   localparam int RANDOM_ITEMS = 558;
   localparam int HOLD_AFTER   = 20;
   localparam int HOLD_CYCLES  = 4000;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [ID_W-1:0]  id;
      logic [LVL_W-1:0] level;
      logic             highest;
   } table_cmd_type;

   typedef struct packed {
      logic [ID_W-1:0] found_id;
      logic            found;
   } query_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   table_cmd_type    cmd_queue[$];
   table_cmd_type    cmd_on_bus;
   query_answer_type query_answers[$];
   logic [LVL_W-1:0] level_mem[NUM_IDS];
   logic             present_mem[NUM_IDS];
   int               items_taken = 0;
   int               answers_seen = 0;
   int               errors = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;

   double_ended_priority_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic int pace();
      return (items_taken / PACE_SPAN) % 4;
   endfunction

   function automatic void post(logic [1:0] cmd, int id, int level, bit highest);
      table_cmd_type c;
      c.cmd     = cmd;
      c.id      = ID_W'(id);
      c.level   = LVL_W'(level);
      c.highest = highest;
      cmd_queue.push_back(c);
   endfunction

   // table update and best-entry search
   task automatic update_table(input table_cmd_type c);
      logic             any;
      logic [ID_W-1:0]  best_id;
      logic [LVL_W-1:0] best_lvl;
      query_answer_type a;
      any      = 1'b0;
      best_id  = '0;
      best_lvl = '0;
      case (c.cmd)
         CMD_ADD: begin
            level_mem[c.id]   = (c.level > MAX_LEVEL) ? MAX_LEVEL : c.level;
            present_mem[c.id] = 1'b1;
         end
         CMD_REMOVE: present_mem[c.id] = 1'b0;
         CMD_QUERY: begin
            for (int i = 0; i < NUM_IDS; i++) begin
               if (present_mem[i] && (!any || (c.highest ? (level_mem[i] >= best_lvl)
                                                          : (level_mem[i] < best_lvl)))) begin
                  any      = 1'b1;
                  best_id  = ID_W'(i);
                  best_lvl = level_mem[i];
               end
            end
            a.found_id = any ? best_id : '0;
            a.found    = any;
            query_answers.push_back(a);
         end
         default: ;
      endcase
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30000000;
      $display("FAILURE");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            update_table(cmd_on_bus);
            items_taken <= items_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_queue.size() != 0 &&
                !(pace() == PACE_SEND_IDLE && $urandom_range(99) < 56) &&
                !(pace() == PACE_BOTH && $urandom_range(99) < 35)) begin
               cmd_on_bus = cmd_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, cmd_on_bus.highest, cmd_on_bus.level, cmd_on_bus.id};
               req_tuser  <= cmd_on_bus.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && answers_seen == HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      query_answer_type want;
      query_answer_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found_id = rsp_tdata[9:0];
            got.found    = rsp_tdata[10];
            answers_seen <= answers_seen + 1;
            if (query_answers.size() == 0) begin
               $error("rsp item with no query pending: found_id %0d found %0d",
                      got.found_id, got.found);
               errors++;
            end else begin
               want = query_answers.pop_front();
               if (got.found_id !== want.found_id) begin
                  $error("found_id mismatch: expected %0d, got %0d",
                         want.found_id, got.found_id);
                  errors++;
               end
               if (got.found !== want.found) begin
                  $error("found mismatch: expected %0d, got %0d", want.found, got.found);
                  errors++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) &&
                       !(pace() == PACE_RECV_STALL && $urandom_range(99) < 56) &&
                       !(pace() == PACE_BOTH && $urandom_range(99) < 35);
      end
   end

   initial begin
      logic [ID_W-1:0] pool[16];
      bit              gen_live[NUM_IDS];
      int              live_ids[$];
      int              counted;
      int              next_pool;
      int              pick;
      int              id;
      int              lvl;

      // directed: empty set, unused code, extremes, ties, saturation, overwrite
      post(CMD_QUERY, 1023, 127, 1);
      post(CMD_QUERY, 0, 0, 0);
      post(CMD_UNUSED, 1023, 127, 1);
      post(CMD_ADD, 0, 0, 0);
      post(CMD_ADD, 1023, 100, 1);
      post(CMD_ADD, 512, 127, 0);
      post(CMD_QUERY, 0, 0, 1);
      post(CMD_QUERY, 0, 0, 0);
      post(CMD_ADD, 341, 0, 0);
      post(CMD_ADD, 682, 85, 1);
      post(CMD_ADD, 0, 42, 0);
      post(CMD_QUERY, 0, 0, 0);
      post(CMD_REMOVE, 1023, 127, 1);
      post(CMD_QUERY, 0, 0, 1);
      post(CMD_REMOVE, 1023, 0, 0);
      post(CMD_QUERY, 0, 0, 1);
      post(CMD_REMOVE, 0, 0, 0);
      post(CMD_REMOVE, 341, 0, 0);
      post(CMD_REMOVE, 512, 0, 0);
      post(CMD_REMOVE, 682, 0, 0);
      post(CMD_QUERY, 0, 0, 0);
      post(CMD_QUERY, 0, 0, 1);

      foreach (gen_live[i]) gen_live[i] = 1'b0;
      counted   = 0;
      next_pool = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted >= next_pool) begin
            foreach (pool[k]) pool[k] = ID_W'($urandom_range(NUM_IDS - 1));
            next_pool = counted + 150;
         end
         pick = $urandom_range(99);
         id   = ($urandom_range(99) < 75) ? int'(pool[$urandom_range(15)])
                                          : $urandom_range(NUM_IDS - 1);
         if (pick < 2) begin
            post(CMD_UNUSED, id, $urandom_range(127), $urandom_range(1));
         end else if (pick < 5 && live_ids.size() != 0) begin
            // empty the table, then look
            foreach (live_ids[k]) begin
               if (gen_live[live_ids[k]]) begin
                  post(CMD_REMOVE, live_ids[k], $urandom_range(127), $urandom_range(1));
                  gen_live[live_ids[k]] = 1'b0;
                  counted++;
               end
            end
            live_ids.delete();
            post(CMD_QUERY, $urandom_range(NUM_IDS - 1), $urandom_range(127),
                 $urandom_range(1));
            counted++;
         end else if (pick < 50) begin
            case ($urandom_range(4))
               0, 1:    lvl = $urandom_range(100);
               2:       lvl = $urandom_range(127);
               default: begin
                  case ($urandom_range(4))
                     0:       lvl = 0;
                     1:       lvl = 1;
                     2:       lvl = 50;
                     3:       lvl = 99;
                     default: lvl = 100;
                  endcase
               end
            endcase
            post(CMD_ADD, id, lvl, $urandom_range(1));
            if (!gen_live[id]) live_ids.push_back(id);
            gen_live[id] = 1'b1;
            counted++;
         end else if (pick < 84) begin
            post(CMD_REMOVE, id, $urandom_range(127), $urandom_range(1));
            gen_live[id] = 1'b0;
            counted++;
         end else begin
            post(CMD_QUERY, id, $urandom_range(127), $urandom_range(1));
            counted++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || req_tvalid || query_answers.size() != 0)
         @(posedge clock);
      repeat (NUM_IDS + 16) @(posedge clock);
      if (query_answers.size() != 0) begin
         $error("%0d query results never arrived", query_answers.size());
         errors++;
      end
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
